FILE: hdl/ida_pkg.sv
// Shared types and constants for the ID allocator.
package ida_pkg;

  localparam int NUM_IDS   = 64;
  localparam int INUSE_BIT = 0;

  localparam int IdxW    = $clog2(NUM_IDS);
  localparam int TopW    = $clog2(NUM_IDS + 1);
  localparam int IdW     = 8;
  localparam int PatW    = 16;
  localparam int FlagW   = 8;
  localparam int GivenW  = 6;

  localparam logic [FlagW-1:0] InuseMask = FlagW'(1 << INUSE_BIT);

  typedef enum logic [2:0] {
    ACT_ALLOC    = 3'd0,
    ACT_FREE     = 3'd1,
    ACT_SET_MASK = 3'd2,
    ACT_CLR_MASK = 3'd3,
    ACT_TST_MASK = 3'd4,
    ACT_SET_FLAG = 3'd5,
    ACT_CLR_FLAG = 3'd6,
    ACT_TST_FLAG = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NONE_FREE  = 2'd1,
    STS_INVALID    = 2'd2,
    STS_NOT_IN_USE = 2'd3
  } sts_code_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request and launch table reads
    logic commit;   // apply updates and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy; // result register holds a result that is not taken this cycle
  } dp_sts_t;

endpackage

FILE: hdl/id_allocator_with_attribute_masks_top.sv
// Top level of the ID allocator with per-ID component masks and flag bytes.
// An accepted request latches its table reads, then executes and writes back, and
// its result is loaded into the result register. A new request is accepted only
// after write-back, since the stack and tables are read through registers.
// A waiting result stalls only the execute step; the next request is held off.
// Reset (rst, synchronous): the stack pointer and all valid bits clear at once,
// so the stack reads as entry i = i and all masks and flags as zero; no sweep.
module id_allocator_with_attribute_masks_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // target_id [7:0], bit_pattern [23:8]
  input  logic [2:0]  s_tuser,   // action [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // given_id [5:0], hit [6], zero [7]
  output logic [1:0]  m_tuser    // status [1:0]
);
  import ida_pkg::*;

  cmd_t            cmd;
  dp_sts_t         sts;
  logic [GivenW-1:0] given_id;
  logic            hit;
  sts_code_t       status;

  ida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ida_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (act_t'(s_tuser)),
    .in_id     (s_tdata[7:0]),
    .in_pat    (s_tdata[23:8]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .given_id  (given_id),
    .hit       (hit),
    .status    (status)
  );

  // Pack the result
  assign m_tdata = {1'b0, hit, given_id};
  assign m_tuser = status;

endmodule

FILE: hdl/ida_ctrl.sv
// Request sequencer for the ID allocator: accept, execute, commit.
module ida_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  ida_pkg::dp_sts_t sts,
  output ida_pkg::cmd_t   cmd
);
  import ida_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // hold off requests while in reset
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the result
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/ida_dp.sv
// Datapath for the ID allocator: free stack, mask and flag tables, result register.
module ida_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  ida_pkg::cmd_t               cmd,
  output ida_pkg::dp_sts_t            sts,
  input  ida_pkg::act_t               in_action,
  input  logic [ida_pkg::IdW-1:0]     in_id,
  input  logic [ida_pkg::PatW-1:0]    in_pat,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ida_pkg::GivenW-1:0]  given_id,
  output logic                        hit,
  output ida_pkg::sts_code_t          status
);
  import ida_pkg::*;

  // Storage
  logic [IdxW-1:0]  stack_mem [NUM_IDS];
  logic [PatW-1:0]  mask_mem  [NUM_IDS];
  logic [FlagW-1:0] flag_mem  [NUM_IDS];
  logic [NUM_IDS-1:0] stk_vld;
  logic [NUM_IDS-1:0] mask_vld;
  logic [NUM_IDS-1:0] flag_vld;
  logic [TopW-1:0]  top;

  // Latched request and registered read data
  act_t             req_action;
  logic [IdW-1:0]   req_id;
  logic [PatW-1:0]  req_pat;
  logic [IdxW-1:0]  stk_q;
  logic             stk_vld_q;
  logic [PatW-1:0]  mask_q;
  logic             mask_vld_q;
  logic [FlagW-1:0] flag_q;
  logic             flag_vld_q;

  // Execute stage signals
  logic [IdxW-1:0]  top_idx;
  logic [IdxW-1:0]  rd_idx;
  logic [IdxW-1:0]  req_idx;
  logic [TopW-1:0]  top_m1;
  logic             id_ok;
  logic             stk_avail;
  logic [IdxW-1:0]  popped;
  logic [PatW-1:0]  mask_rd;
  logic [FlagW-1:0] flag_rd;
  logic             mask_we;
  logic             flag_we;
  logic [IdxW-1:0]  wr_idx;
  logic [PatW-1:0]  mask_wd;
  logic [FlagW-1:0] flag_wd;
  logic             top_inc;
  logic             top_dec;
  logic             alloc_ok;
  logic [GivenW-1:0] given_next;
  logic             hit_next;
  sts_code_t        status_next;

  assign top_idx   = top[IdxW-1:0];
  assign rd_idx    = in_id[IdxW-1:0];
  assign req_idx   = req_id[IdxW-1:0];
  assign top_m1    = top - TopW'(1);
  assign id_ok     = 32'(req_id) < NUM_IDS;
  assign stk_avail = 32'(top) < NUM_IDS;
  assign popped    = stk_vld_q ? stk_q : top_idx;
  assign mask_rd   = mask_vld_q ? mask_q : '0;
  assign flag_rd   = flag_vld_q ? flag_q : '0;

  assign sts.out_busy = m_tvalid && !m_tready;

  // Latch request and read all tables
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= in_action;
      req_id     <= in_id;
      req_pat    <= in_pat;
      stk_q      <= stack_mem[top_idx];
      stk_vld_q  <= stk_vld[top_idx];
      mask_q     <= mask_mem[rd_idx];
      mask_vld_q <= mask_vld[rd_idx];
      flag_q     <= flag_mem[rd_idx];
      flag_vld_q <= flag_vld[rd_idx];
    end
  end

  // Decode the request into updates and a result
  always_comb begin
    mask_we     = 1'b0;
    flag_we     = 1'b0;
    wr_idx      = req_idx;
    mask_wd     = mask_rd;
    flag_wd     = flag_rd;
    top_inc     = 1'b0;
    top_dec     = 1'b0;
    alloc_ok    = 1'b0;
    given_next  = '0;
    hit_next    = 1'b0;
    status_next = STS_OK;
    priority if (req_action == ACT_ALLOC) begin
      if (!stk_avail) begin
        status_next = STS_NONE_FREE;
      end else begin
        alloc_ok   = 1'b1;
        top_inc    = 1'b1;
        wr_idx     = popped;
        mask_we    = 1'b1;
        flag_we    = 1'b1;
        mask_wd    = '0;
        flag_wd    = InuseMask;
        given_next = GivenW'(popped);
      end
    end else if (!id_ok) begin
      status_next = STS_INVALID;
    end else begin
      unique case (req_action)
        ACT_FREE: begin
          if (((flag_rd & InuseMask) == '0) || (top == '0)) begin
            status_next = STS_NOT_IN_USE;
          end else begin
            top_dec = 1'b1;
            mask_we = 1'b1;
            flag_we = 1'b1;
            mask_wd = '0;
            flag_wd = '0;
          end
        end
        ACT_SET_MASK: begin
          mask_we = 1'b1;
          mask_wd = mask_rd | req_pat;
        end
        ACT_CLR_MASK: begin
          mask_we = 1'b1;
          mask_wd = mask_rd & ~req_pat;
        end
        ACT_TST_MASK: hit_next = |(mask_rd & req_pat);
        ACT_SET_FLAG: begin
          flag_we = 1'b1;
          flag_wd = flag_rd | req_pat[FlagW-1:0];
        end
        ACT_CLR_FLAG: begin
          flag_we = 1'b1;
          flag_wd = flag_rd & ~req_pat[FlagW-1:0];
        end
        ACT_TST_FLAG: hit_next = |(flag_rd & req_pat[FlagW-1:0]);
        default: hit_next = 1'b0;
      endcase
    end
  end

  // Table and stack writes
  always_ff @(posedge clk) begin
    if (cmd.commit && mask_we) begin
      mask_mem[wr_idx] <= mask_wd;
    end
    if (cmd.commit && flag_we) begin
      flag_mem[wr_idx] <= flag_wd;
    end
    if (cmd.commit && top_dec) begin
      stack_mem[top_m1[IdxW-1:0]] <= req_idx;
    end
  end

  // Valid bits and stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_vld  <= '0;
      mask_vld <= '0;
      flag_vld <= '0;
      top      <= '0;
    end else if (cmd.commit) begin
      if (mask_we) begin
        mask_vld[wr_idx] <= 1'b1;
      end
      if (flag_we) begin
        flag_vld[wr_idx] <= 1'b1;
      end
      if (top_dec) begin
        stk_vld[top_m1[IdxW-1:0]] <= 1'b1;
        top <= top_m1;
      end else if (top_inc) begin
        top <= top + TopW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      given_id <= given_next;
      hit      <= hit_next;
      status   <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    32'(top) <= NUM_IDS)
    else $error("stack pointer beyond the ID count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("result overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed request gave no result");

  a_alloc_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && alloc_ok) |=> (top == $past(top) + TopW'(1)))
    else $error("allocate did not advance the stack pointer");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");
`endif

endmodule
